[hw/rtl/cft_pkg.sv]
// ----------------------------------------------------------------------------
// cft_pkg
// Shared sizes, command word and helpers for the cumulative frequency table.
// ----------------------------------------------------------------------------
package cft_pkg;

    localparam int MAX_SYMS    = 256;
    localparam int COUNT_W     = 32;
    localparam int SYM_IDX_W   = $clog2(MAX_SYMS);
    localparam int SYM_W       = SYM_IDX_W + 1;
    localparam int TOP_MAX     = SYM_IDX_W;
    localparam int LVL_W       = $clog2(TOP_MAX + 1);
    localparam int CNT_W       = $clog2(TOP_MAX + 2);
    localparam int STORE_DEPTH = 2 * MAX_SYMS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 3;

    localparam logic [ADDR_W-3:0] REG_SYMS = '0;

    typedef enum logic [1:0] {
        OP_INC    = 2'd0,
        OP_CUM    = 2'd1,
        OP_SINGLE = 2'd2,
        OP_FIND   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [SYM_W-1:0]    sym;
        logic [COUNT_W-1:0]  amount;
        logic [COUNT_W-1:0]  target;
        logic                sym_err;
        logic                at_total;
    } cmd_t;

    function automatic logic [SYM_W-1:0] clamp_syms(input logic [SYM_W-1:0] v);
        logic [SYM_W-1:0] r;
        r = v;
        if (v == '0)
            r = SYM_W'(1);
        else if (v > SYM_W'(MAX_SYMS))
            r = SYM_W'(MAX_SYMS);
        return r;
    endfunction

    function automatic logic [LVL_W-1:0] ceil_log2(input logic [SYM_W-1:0] n);
        logic [LVL_W-1:0] t;
        t = '0;
        for (int i = 0; i <= TOP_MAX; i++)
        begin
            if ((SYM_W'(1) << i) < n)
                t = LVL_W'(i + 1);
        end
        return t;
    endfunction

    // entry j of level lvl: 2^top - 2^(top-lvl) + j
    function automatic logic [STORE_AW-1:0] slot_addr(
        input logic [LVL_W-1:0]     top,
        input logic [LVL_W-1:0]     lvl,
        input logic [SYM_IDX_W-1:0] j
    );
        logic [STORE_AW-1:0] one;
        one = STORE_AW'(1);
        return (one << top) - (one << (top - lvl)) + STORE_AW'(j);
    endfunction

endpackage

[hw/rtl/cft_ram.sv]
// ----------------------------------------------------------------------------
// cft_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

[hw/rtl/cft_front.sv]
// ----------------------------------------------------------------------------
// cft_front
// Accepts input words, range-checks the symbol and pushes a command word.
// ----------------------------------------------------------------------------
module cft_front import cft_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          op,
    input  logic [SYM_W-1:0]    symbol,
    input  logic signed [COUNT_W-1:0] amount,
    input  logic [COUNT_W-1:0]  target,
    input  logic [SYM_W-1:0]    syms_in_use,
    input  logic                q_full,
    input  logic                clr_busy,
    output logic                push,
    output cmd_t                push_cmd
);

    op_t  op_dec;

    assign in_stall = q_full || clr_busy;
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        op_dec            = op_t'(op);
        push_cmd.op       = op_dec;
        push_cmd.sym      = symbol;
        push_cmd.amount   = $unsigned(amount);
        push_cmd.target   = target;
        push_cmd.at_total = (op_dec == OP_CUM) && (symbol == syms_in_use);
        case (op_dec)
            OP_INC, OP_SINGLE: push_cmd.sym_err = (symbol >= syms_in_use);
            OP_CUM:            push_cmd.sym_err = (symbol > syms_in_use);
            default:           push_cmd.sym_err = 1'b0;
        endcase
    end

endmodule

[hw/rtl/cft_queue.sv]
// ----------------------------------------------------------------------------
// cft_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module cft_queue import cft_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic q_valid,
    input  logic pop,
    output cmd_t q_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[hw/rtl/cft_back.sv]
// ----------------------------------------------------------------------------
// cft_back
// Walks the tree levels on the count RAM, one read per cycle, and
// delivers the result word through an output register.
// ----------------------------------------------------------------------------
module cft_back import cft_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear_start,
    input  logic [SYM_W-1:0]     syms_in_use,
    input  logic [LVL_W-1:0]     top_level,
    input  logic                 q_valid,
    input  cmd_t                 q_cmd,
    output logic                 q_pop,
    output logic                 clr_busy,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [COUNT_W-1:0]   value,
    output logic [SYM_IDX_W-1:0] found_symbol,
    output logic                 error
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [CNT_W-1:0]     iss_cnt_reg, iss_cnt_next;
    logic [LVL_W-1:0]     iss_lvl_reg, iss_lvl_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [LVL_W-1:0]     rd_lvl_reg, rd_lvl_next;
    logic [STORE_AW-1:0]  rd_addr_reg, rd_addr_next;
    logic [COUNT_W-1:0]   acc_reg, acc_next;
    logic [SYM_IDX_W-1:0] ch_reg, ch_next;
    logic [COUNT_W-1:0]   total_reg, total_next;
    logic                 clr_busy_reg, clr_busy_next;
    logic [STORE_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [COUNT_W-1:0]   res_value_reg, res_value_next;
    logic [SYM_IDX_W-1:0] res_found_reg, res_found_next;
    logic                 res_err_reg, res_err_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]   out_value_reg, out_value_next;
    logic [SYM_IDX_W-1:0] out_found_reg, out_found_next;
    logic                 out_err_reg, out_err_next;

    logic                 ram_we;
    logic [STORE_AW-1:0]  ram_waddr;
    logic [COUNT_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [STORE_AW-1:0]  ram_raddr;
    logic [COUNT_W-1:0]   ram_rdata;

    logic                 sym_bit;
    logic [COUNT_W-1:0]   acc_new;
    logic [SYM_IDX_W-1:0] ch_new;
    logic [COUNT_W-1:0]   wr_sum;
    logic [SYM_IDX_W-1:0] iss_j;
    logic [STORE_AW-1:0]  iss_addr;
    logic                 ascending;
    logic [SYM_IDX_W-1:0] found_clamped;
    logic                 imm_err;
    logic                 imm;

    cft_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign clr_busy     = clr_busy_reg;
    assign out_valid    = out_valid_reg;
    assign value        = out_value_reg;
    assign found_symbol = out_found_reg;
    assign error        = out_err_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        iss_cnt_next   = iss_cnt_reg;
        iss_lvl_next   = iss_lvl_reg;
        rd_vld_next    = 1'b0;
        rd_lvl_next    = rd_lvl_reg;
        rd_addr_next   = rd_addr_reg;
        acc_next       = acc_reg;
        ch_next        = ch_reg;
        total_next     = total_reg;
        clr_busy_next  = clr_busy_reg;
        clr_cnt_next   = clr_cnt_reg;
        res_value_next = res_value_reg;
        res_found_next = res_found_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_value_next = out_value_reg;
        out_found_next = out_found_reg;
        out_err_next   = out_err_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = rd_addr_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        // returning tree entry
        sym_bit = cmd_reg.sym[rd_lvl_reg];
        acc_new = acc_reg;
        ch_new  = ch_reg;
        wr_sum  = ram_rdata + cmd_reg.amount;
        if (rd_vld_reg)
        begin
            case (cmd_reg.op)
                OP_CUM:
                begin
                    if (sym_bit)
                        acc_new = acc_reg + ram_rdata;
                end
                OP_SINGLE:
                    acc_new = sym_bit ? acc_reg - ram_rdata : ram_rdata;
                OP_FIND:
                begin
                    if (acc_reg < ram_rdata)
                        ch_new = SYM_IDX_W'({ch_reg, 1'b0});
                    else
                    begin
                        ch_new  = SYM_IDX_W'({ch_reg, 1'b1});
                        acc_new = acc_reg - ram_rdata;
                    end
                end
                default: ;
            endcase
        end

        // next read
        ascending = (cmd_reg.op == OP_INC) || (cmd_reg.op == OP_CUM);
        iss_j     = (cmd_reg.op == OP_FIND) ? ch_new
                  : SYM_IDX_W'(cmd_reg.sym >> (iss_lvl_reg + 1'b1));
        iss_addr  = slot_addr(top_level, iss_lvl_reg, iss_j);

        found_clamped = ({1'b0, ch_new} >= syms_in_use) ? SYM_IDX_W'(syms_in_use - 1'b1)
                      : ch_new;

        imm_err = q_cmd.sym_err || ((q_cmd.op == OP_FIND) && (q_cmd.target >= total_reg));
        imm     = imm_err || q_cmd.at_total
               || (((q_cmd.op == OP_SINGLE) || (q_cmd.op == OP_FIND)) && (top_level == '0));

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && !clr_busy_reg)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    ch_next  = '0;
                    case (q_cmd.op)
                        OP_SINGLE: acc_next = total_reg;
                        OP_FIND:   acc_next = q_cmd.target;
                        default:   acc_next = '0;
                    endcase
                    if ((q_cmd.op == OP_INC) || (q_cmd.op == OP_CUM))
                    begin
                        iss_cnt_next = CNT_W'(top_level) + 1'b1;
                        iss_lvl_next = '0;
                    end
                    else
                    begin
                        iss_cnt_next = CNT_W'(top_level);
                        iss_lvl_next = top_level - 1'b1;
                    end
                    if (imm)
                    begin
                        res_err_next   = imm_err;
                        res_found_next = '0;
                        res_value_next = (!imm_err && (q_cmd.at_total || (q_cmd.op == OP_SINGLE)))
                                       ? total_reg : '0;
                        state_next     = ST_DONE;
                    end
                    else
                        state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (rd_vld_reg)
                begin
                    acc_next = acc_new;
                    ch_next  = ch_new;
                    if ((cmd_reg.op == OP_INC) && !sym_bit)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = rd_addr_reg;
                        ram_wdata = wr_sum;
                        if (rd_lvl_reg == top_level)
                            total_next = wr_sum;
                    end
                end
                if (iss_cnt_reg != '0)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = iss_addr;
                    rd_vld_next  = 1'b1;
                    rd_lvl_next  = iss_lvl_reg;
                    rd_addr_next = iss_addr;
                    iss_cnt_next = iss_cnt_reg - 1'b1;
                    iss_lvl_next = ascending ? iss_lvl_reg + 1'b1 : iss_lvl_reg - 1'b1;
                end
                else if (rd_vld_reg)
                begin
                    res_err_next   = 1'b0;
                    res_value_next = ((cmd_reg.op == OP_CUM) || (cmd_reg.op == OP_SINGLE))
                                   ? acc_new : '0;
                    res_found_next = (cmd_reg.op == OP_FIND) ? found_clamped : '0;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_found_next = res_found_reg;
                    out_err_next   = res_err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // clearing pass
        if (clr_busy_reg)
        begin
            ram_we       = 1'b1;
            ram_waddr    = clr_cnt_reg;
            ram_wdata    = '0;
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == STORE_AW'(STORE_DEPTH - 1))
                clr_busy_next = 1'b0;
        end
        if (clear_start)
        begin
            clr_busy_next = 1'b1;
            clr_cnt_next  = '0;
            total_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iss_cnt_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            total_reg     <= '0;
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_cnt_reg   <= iss_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            total_reg     <= total_next;
            clr_busy_reg  <= clr_busy_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        iss_lvl_reg   <= iss_lvl_next;
        rd_lvl_reg    <= rd_lvl_next;
        rd_addr_reg   <= rd_addr_next;
        acc_reg       <= acc_next;
        ch_reg        <= ch_next;
        res_value_reg <= res_value_next;
        res_found_reg <= res_found_next;
        res_err_reg   <= res_err_next;
        out_value_reg <= out_value_next;
        out_found_reg <= out_found_next;
        out_err_reg   <= out_err_next;
    end

endmodule

[hw/rtl/cumulative_frequency_table.sv]
// ----------------------------------------------------------------------------
// cumulative_frequency_table
// Per-symbol frequency counts kept as a bit-level tree in one RAM, with
// increment, cumulative lookup, single lookup and find-symbol operations.
//
//   channel  | direction | handshake          | word
//   ---------+-----------+--------------------+--------------------------------
//   in       | in        | in_valid/in_stall  | op, symbol, amount, target
//   out      | out       | out_valid/out_stall| value, found_symbol, error
//   config   | in        | APB psel/penable   | symbols_in_use at 0x0
//
// With T = ceil(log2(symbols_in_use)), increment and cumulative lookup walk
// T+1 tree levels after the queue pop (T for single lookup and find symbol),
// reading one tree level per cycle on the RAM read port. Out-of-range
// and grand-total requests, and single lookups and find symbol with T = 0,
// skip the tree walk and go to the output register. After reset and after
// each write of symbols_in_use a clearing pass zeroes every RAM entry,
// during which in_stall is high. A stalled output holds one result, the back
// holds a second and two more commands wait in the queue.
// ----------------------------------------------------------------------------
module cumulative_frequency_table import cft_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 op,
    input  logic [SYM_W-1:0]           symbol,
    input  logic signed [COUNT_W-1:0]  amount,
    input  logic [COUNT_W-1:0]         target,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [COUNT_W-1:0]         value,
    output logic [SYM_IDX_W-1:0]       found_symbol,
    output logic                       error,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    logic [SYM_W-1:0] syms_reg, syms_next;
    logic [LVL_W-1:0] top_reg, top_next;
    logic             cfg_wr;
    logic             reg_hit;

    logic             push;
    cmd_t             push_cmd;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    cmd_t             q_cmd;
    logic             clr_busy;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[ADDR_W-1:2] == REG_SYMS);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? DATA_W'(syms_reg) : '0;

    always_comb
    begin
        syms_next = syms_reg;
        top_next  = top_reg;
        if (cfg_wr)
        begin
            syms_next = clamp_syms(pwdata[SYM_W-1:0]);
            top_next  = ceil_log2(clamp_syms(pwdata[SYM_W-1:0]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            syms_reg <= SYM_W'(MAX_SYMS);
            top_reg  <= LVL_W'(TOP_MAX);
        end
        else
        begin
            syms_reg <= syms_next;
            top_reg  <= top_next;
        end
    end

    cft_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .symbol      (symbol),
        .amount      (amount),
        .target      (target),
        .syms_in_use (syms_reg),
        .q_full      (q_full),
        .clr_busy    (clr_busy),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    cft_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .q_valid  (q_valid),
        .pop      (q_pop),
        .q_cmd    (q_cmd)
    );

    cft_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear_start  (cfg_wr),
        .syms_in_use  (syms_reg),
        .top_level    (top_reg),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .clr_busy     (clr_busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value        (value),
        .found_symbol (found_symbol),
        .error        (error)
    );

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cumulative_frequency_table: a queue-fed driver and a
// monitor with random gaps and stalls. A local copy of the frequency tree
// predicts every result word, which the monitor checks field by field.
// Several symbol counts are programmed, including both extremes, zero and
// values above the maximum.
// ----------------------------------------------------------------------------
module testbench;
    import cft_pkg::*;

    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned RANDOM_PER_PHASE = 35;
    localparam logic [ADDR_W-1:0] SYMS_ADDR = {REG_SYMS, 2'b00};

    typedef struct packed {
        op_t               op;
        logic [SYM_W-1:0]  sym;
        logic [COUNT_W-1:0] amount;
        logic [COUNT_W-1:0] target;
    } word_t;

    typedef struct packed {
        logic [COUNT_W-1:0]   value;
        logic [SYM_IDX_W-1:0] found;
        logic                 err;
    } result_t;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [1:0]                 op = '0;
    logic [SYM_W-1:0]           symbol = '0;
    logic signed [COUNT_W-1:0]  amount = '0;
    logic [COUNT_W-1:0]         target = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [COUNT_W-1:0]         value;
    logic [SYM_IDX_W-1:0]       found_symbol;
    logic                       error;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [ADDR_W-1:0]          paddr = '0;
    logic [DATA_W-1:0]          pwdata = '0;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;

    word_t       pending_q [$];
    result_t     expected_q [$];
    word_t       shown_word;
    result_t     head_result;
    int unsigned words_queued = 0;
    int unsigned words_taken = 0;
    int unsigned errors = 0;
    int unsigned in_wait = 0;
    int unsigned out_hold = 0;
    bit          in_calm = 1'b0;
    bit          out_calm = 1'b0;
    int unsigned phase_syms [10] = '{1, 2, 0, 3, 511, 5, 129, 300, 200, 64};

    logic [COUNT_W-1:0] freq_tree [STORE_DEPTH];
    int unsigned        sym_count;
    int unsigned        tree_top;

    cumulative_frequency_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .symbol       (symbol),
        .amount       (amount),
        .target       (target),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value        (value),
        .found_symbol (found_symbol),
        .error        (error),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---- frequency tree predictor ----

    function automatic int unsigned tree_index(input int unsigned lvl, input int unsigned j);
        return ((1 << tree_top) - (1 << (tree_top - lvl))) + j;
    endfunction

    function automatic logic [COUNT_W-1:0] tree_read(input int unsigned lvl,
                                                     input int unsigned j);
        int unsigned k;
        k = tree_index(lvl, j);
        return (k < STORE_DEPTH) ? freq_tree[k] : '0;
    endfunction

    function automatic void tree_add(input int unsigned lvl, input int unsigned j,
                                     input logic [COUNT_W-1:0] v);
        int unsigned k;
        k = tree_index(lvl, j);
        if (k < STORE_DEPTH)
            freq_tree[k] = freq_tree[k] + v;
    endfunction

    function automatic void set_sym_count(input logic [SYM_W-1:0] v);
        int unsigned n;
        n = v;
        if (n < 1)
            n = 1;
        if (n > MAX_SYMS)
            n = MAX_SYMS;
        sym_count = n;
        tree_top = 0;
        while ((1 << tree_top) < n)
            tree_top++;
        foreach (freq_tree[k])
            freq_tree[k] = '0;
    endfunction

    function automatic result_t predict_word(input word_t w);
        result_t            r;
        logic [COUNT_W-1:0] total;
        logic [COUNT_W-1:0] acc;
        logic [COUNT_W-1:0] e;
        logic [COUNT_W-1:0] rem;
        int unsigned        s;
        int unsigned        ch;
        r = '0;
        total = tree_read(tree_top, 0);
        s = w.sym;
        case (w.op)
            OP_INC:
            begin
                if (s >= sym_count)
                    r.err = 1'b1;
                else
                    for (int i = 0; i <= int'(tree_top); i++)
                        if (((s >> i) & 1) == 0)
                            tree_add(i, s >> (i + 1), w.amount);
            end
            OP_CUM:
            begin
                if (s > sym_count)
                    r.err = 1'b1;
                else if (s == sym_count)
                    r.value = total;
                else
                begin
                    acc = '0;
                    for (int i = 0; i <= int'(tree_top); i++)
                        if (((s >> i) & 1) != 0)
                            acc = acc + tree_read(i, s >> (i + 1));
                    r.value = acc;
                end
            end
            OP_SINGLE:
            begin
                if (s >= sym_count)
                    r.err = 1'b1;
                else
                begin
                    acc = total;
                    for (int i = int'(tree_top) - 1; i >= 0; i--)
                    begin
                        e = tree_read(i, s >> (i + 1));
                        if (((s >> i) & 1) != 0)
                            acc = acc - e;
                        else
                            acc = e;
                    end
                    r.value = acc;
                end
            end
            default:
            begin
                if (w.target >= total)
                    r.err = 1'b1;
                else
                begin
                    ch = 0;
                    rem = w.target;
                    for (int i = int'(tree_top) - 1; i >= 0; i--)
                    begin
                        e = tree_read(i, ch);
                        if (rem < e)
                            ch = ch * 2;
                        else
                        begin
                            ch = ch * 2 + 1;
                            rem = rem - e;
                        end
                    end
                    // non-monotone tree can descend past the last symbol
                    if (ch >= sym_count)
                        ch = sym_count - 1;
                    r.found = SYM_IDX_W'(ch);
                end
            end
        endcase
        return r;
    endfunction

    function automatic int unsigned draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    // ---- driver ----

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_q.push_back(predict_word(shown_word));
                words_taken++;
                if ($urandom_range(0, 31) == 0)
                    in_calm = !in_calm;
                in_wait = draw_wait(in_calm);
            end
            if (!in_valid || !in_stall)
            begin
                if (in_wait != 0)
                begin
                    in_wait--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() != 0)
                begin
                    shown_word = pending_q.pop_front();
                    in_valid <= 1'b1;
                    op <= shown_word.op;
                    symbol <= shown_word.sym;
                    amount <= shown_word.amount;
                    target <= shown_word.target;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---- monitor ----

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected word: value %h found_symbol %h error %b",
                           value, found_symbol, error);
                    errors++;
                end
                else
                begin
                    head_result = expected_q.pop_front();
                    if (value !== head_result.value)
                    begin
                        $error("value: expected %h, got %h", head_result.value, value);
                        errors++;
                    end
                    if (found_symbol !== head_result.found)
                    begin
                        $error("found_symbol: expected %h, got %h",
                               head_result.found, found_symbol);
                        errors++;
                    end
                    if (error !== head_result.err)
                    begin
                        $error("error: expected %b, got %b", head_result.err, error);
                        errors++;
                    end
                end
                if ($urandom_range(0, 31) == 0)
                    out_calm = !out_calm;
                out_hold = draw_wait(out_calm);
            end
            if (out_hold != 0)
            begin
                out_hold--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ---- stimulus ----

    task automatic push_word(input op_t o, input int unsigned s,
                             input logic [COUNT_W-1:0] a, input logic [COUNT_W-1:0] t);
        word_t w;
        w.op = o;
        w.sym = SYM_W'(s);
        w.amount = a;
        w.target = t;
        pending_q.push_back(w);
        words_queued++;
    endtask

    task automatic wait_idle();
        while (words_taken != words_queued || expected_q.size() != 0 || in_stall)
            @(posedge clk);
    endtask

    task automatic write_syms(input logic [SYM_W-1:0] v);
        logic [DATA_W-1:0] data;
        wait_idle();
        data = DATA_W'(v);
        if ($urandom_range(0, 1) == 0)
            data[DATA_W-1:SYM_W] = (DATA_W - SYM_W)'($urandom());
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SYMS_ADDR;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        set_sym_count(data[SYM_W-1:0]);
    endtask

    task automatic queue_random(input int unsigned n_items);
        int unsigned        pick;
        int unsigned        s;
        logic [COUNT_W-1:0] a;
        logic [COUNT_W-1:0] t;
        op_t                o;
        longint             approx;
        approx = 0;
        repeat (n_items)
        begin
            pick = $urandom_range(0, 9);
            o = (pick < 4) ? OP_INC : (pick < 6) ? OP_CUM : (pick < 8) ? OP_SINGLE : OP_FIND;
            pick = $urandom_range(0, 19);
            if (pick < 17)
                s = $urandom_range(0, sym_count - 1);
            else if (pick < 18)
                s = sym_count;
            else
                s = $urandom_range(0, 511);
            pick = $urandom_range(0, 19);
            if (pick < 14)
                a = $urandom_range(0, 300);
            else if (pick < 17)
                a = COUNT_W'(0) - COUNT_W'($urandom_range(1, 50));
            else
                a = $urandom();
            if (o == OP_INC && s < sym_count)
                approx = approx + longint'(signed'(a));
            if (approx > 0 && approx <= 64'h0000_0000_FFFF_FFFF && $urandom_range(0, 4) != 0)
                t = $urandom_range(0, 32'(approx) + 2);
            else
                t = $urandom();
            push_word(o, s, a, t);
        end
    endtask

    initial
    begin
        set_sym_count(SYM_W'(MAX_SYMS));
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // empty table, then extremes of symbol, amount and target
        push_word(OP_FIND, 0, '0, '0);
        push_word(OP_CUM, 256, '0, '0);
        push_word(OP_INC, 0, 32'h7FFF_FFFF, '0);
        push_word(OP_INC, 255, 32'h8000_0000, '0);
        push_word(OP_INC, 256, 32'h1, '0);
        push_word(OP_INC, 511, 32'h1, '0);
        push_word(OP_INC, 128, 32'h3, '0);
        push_word(OP_INC, 77, 32'hFFFF_FFFF, '0);
        push_word(OP_INC, 1, 32'd100, '0);
        push_word(OP_CUM, 0, '0, '0);
        push_word(OP_CUM, 1, '0, '0);
        push_word(OP_CUM, 128, '0, '0);
        push_word(OP_CUM, 255, '0, '0);
        push_word(OP_CUM, 256, '0, '0);
        push_word(OP_CUM, 257, '0, '0);
        push_word(OP_CUM, 511, '0, '0);
        push_word(OP_SINGLE, 0, '0, '0);
        push_word(OP_SINGLE, 255, '0, '0);
        push_word(OP_SINGLE, 77, '0, '0);
        push_word(OP_SINGLE, 256, '0, '0);
        push_word(OP_SINGLE, 511, '0, '0);
        push_word(OP_FIND, 0, '0, 32'd0);
        push_word(OP_FIND, 0, '0, 32'd50);
        push_word(OP_FIND, 0, '0, 32'd100);
        push_word(OP_FIND, 0, '0, 32'hFFFF_FFFF);
        queue_random(RANDOM_PER_PHASE);

        foreach (phase_syms[k])
        begin
            write_syms(SYM_W'(phase_syms[k]));
            queue_random(RANDOM_PER_PHASE);
        end
        write_syms(SYM_W'($urandom_range(1, 256)));
        queue_random(RANDOM_PER_PHASE);
        write_syms(SYM_W'($urandom_range(0, 511)));
        queue_random(RANDOM_PER_PHASE);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ---- watchdog ----

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
